@@ rtl/i2da_pkg.sv @@
// Shared constants, types and the null text table for the decimal text converter.
package i2da_pkg;

  localparam int VALUE_W = 64;
  localparam int MAG_W   = VALUE_W - 1;
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = 19;
  localparam int BCD_W   = DIGITS * DIGIT_W;
  localparam int CHAR_W  = 7;
  localparam int SHIFT_W = $clog2(MAG_W);
  localparam int LEFT_W  = $clog2(DIGITS + 1);

  localparam logic [VALUE_W-1:0] NULL_MARK  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_N     = 7'h6E;
  localparam logic [CHAR_W-1:0]  CHAR_U     = 7'h75;
  localparam logic [CHAR_W-1:0]  CHAR_L     = 7'h6C;

  typedef struct packed {
    logic             is_null;
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_res_t;

  function automatic logic [CHAR_W-1:0] null_char(input logic [1:0] idx);
    logic [CHAR_W-1:0] ch;
    unique case (idx)
      2'd0:    ch = CHAR_N;
      2'd1:    ch = CHAR_U;
      default: ch = CHAR_L;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/i2da_bcd.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
module i2da_bcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [i2da_pkg::VALUE_W-1:0] in_value,
  output logic                      res_valid,
  input  logic                      res_take,
  output i2da_pkg::conv_res_t       res
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

  cstate_t                          state_r;
  logic [i2da_pkg::SHIFT_W-1:0]     cnt_r;
  logic [i2da_pkg::MAG_W-1:0]       bin_r;
  logic [i2da_pkg::BCD_W-1:0]       bcd_r;
  logic                             null_r;
  logic                             neg_r;
  logic [i2da_pkg::BCD_W-1:0]       adj;
  logic [i2da_pkg::VALUE_W-1:0]     mag;
  logic [i2da_pkg::DIGIT_W-1:0]     d;

  assign mag = in_value[i2da_pkg::VALUE_W-1] ?
               i2da_pkg::VALUE_W'(~in_value + 64'd1) : in_value;

  // Digits of 5 or more get 3 added before the doubling shift.
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < i2da_pkg::DIGITS; i++) begin
      d = bcd_r[i*i2da_pkg::DIGIT_W +: i2da_pkg::DIGIT_W];
      adj[i*i2da_pkg::DIGIT_W +: i2da_pkg::DIGIT_W] =
        (d >= 4'd5) ? i2da_pkg::DIGIT_W'(d + 4'd3) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (in_valid) begin
            bin_r   <= mag[i2da_pkg::MAG_W-1:0];
            bcd_r   <= '0;
            null_r  <= (in_value == i2da_pkg::NULL_MARK);
            neg_r   <= in_value[i2da_pkg::VALUE_W-1];
            cnt_r   <= i2da_pkg::SHIFT_W'(i2da_pkg::MAG_W - 1);
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          bcd_r <= {adj[i2da_pkg::BCD_W-2:0], bin_r[i2da_pkg::MAG_W-1]};
          bin_r <= {bin_r[i2da_pkg::MAG_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= C_DONE;
        end
        default: begin
          if (res_take) state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign in_stall    = (state_r != C_IDLE);
  assign res_valid   = (state_r == C_DONE);
  assign res.is_null = null_r;
  assign res.neg     = neg_r;
  assign res.bcd     = bcd_r;

endmodule

@@ rtl/i2da_emit.sv @@
// Character serializer: drops leading zeros and sends sign, digits or null text.
module i2da_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_valid,
  output logic                        res_take,
  input  i2da_pkg::conv_res_t         res,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [i2da_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);

  typedef enum logic [2:0] {E_IDLE, E_SKIP, E_SIGN, E_DIG, E_NULL} estate_t;

  estate_t                         state_r;
  logic [i2da_pkg::BCD_W-1:0]      dig_r;
  logic [i2da_pkg::LEFT_W-1:0]     left_r;
  logic [1:0]                      idx_r;
  logic                            neg_r;
  logic                            out_valid_r;
  logic [i2da_pkg::CHAR_W-1:0]     out_char_r;
  logic                            out_last_r;
  logic                            slot_free;
  logic                            emit_go;
  logic [i2da_pkg::DIGIT_W-1:0]    top;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit_go   = slot_free &&
                     (state_r == E_SIGN || state_r == E_DIG || state_r == E_NULL);
  assign top       = dig_r[i2da_pkg::BCD_W-1 -: i2da_pkg::DIGIT_W];
  assign res_take  = (state_r == E_IDLE) && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new character, drop a taken one, hold a stalled one.
      if (emit_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        E_IDLE: begin
          if (res_valid) begin
            dig_r   <= res.bcd;
            neg_r   <= res.neg;
            left_r  <= i2da_pkg::LEFT_W'(i2da_pkg::DIGITS);
            idx_r   <= 2'd0;
            state_r <= res.is_null ? E_NULL : E_SKIP;
          end
        end
        E_SKIP: begin
          if (top == '0 && left_r != i2da_pkg::LEFT_W'(1)) begin
            dig_r  <= {dig_r[i2da_pkg::BCD_W-i2da_pkg::DIGIT_W-1:0],
                       {i2da_pkg::DIGIT_W{1'b0}}};
            left_r <= left_r - 1'b1;
          end else begin
            state_r <= neg_r ? E_SIGN : E_DIG;
          end
        end
        E_SIGN: begin
          if (slot_free) begin
            out_char_r  <= i2da_pkg::CHAR_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= E_DIG;
          end
        end
        E_DIG: begin
          if (slot_free) begin
            out_char_r  <= i2da_pkg::CHAR_W'(i2da_pkg::CHAR_ZERO + {3'b000, top});
            out_last_r  <= (left_r == i2da_pkg::LEFT_W'(1));
            dig_r       <= {dig_r[i2da_pkg::BCD_W-i2da_pkg::DIGIT_W-1:0],
                            {i2da_pkg::DIGIT_W{1'b0}}};
            left_r      <= left_r - 1'b1;
            if (left_r == i2da_pkg::LEFT_W'(1)) state_r <= E_IDLE;
          end
        end
        default: begin
          if (slot_free) begin
            out_char_r  <= i2da_pkg::null_char(idx_r);
            out_last_r  <= (idx_r == 2'd3);
            idx_r       <= idx_r + 1'b1;
            if (idx_r == 2'd3) state_r <= E_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/int64_to_decimal_ascii.sv @@
// Top level: signed 64-bit integer in, decimal ASCII text out one character per request.
//
// Input channel (in_valid/in_stall/in_value): one signed 64-bit value per request.
// Output channel (out_valid/out_stall/out_char/out_last): one ASCII character per
// request, most significant first, out_last high on the final character.
// Negative values start with '-', zero gives a single '0', and the most negative
// value gives the text "null".
// The converter shifts one magnitude bit per cycle through a BCD register. The
// serializer then drops leading zero digits, up to 18 of them, one per cycle,
// and sends one character per cycle while the receiver does not stall.
// Conversion of the next value overlaps the sending of the current one; long
// texts on a stalling receiver can hold up the next value.
// A stall holds the current character in the output register; the serializer and
// then the converter wait, and in_stall stays high until the converter is free.
// Reset (synchronous, rst_n low) drops any value in flight and clears out_valid.
module int64_to_decimal_ascii (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [i2da_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [i2da_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);

  logic                res_valid;
  logic                res_take;
  i2da_pkg::conv_res_t res;

  i2da_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  i2da_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  // Converter is busy right after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("converter took a request but did not go busy");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char == i2da_pkg::CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  // Hand-off to the serializer only happens with a finished conversion.
  a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> res_valid)
    else $error("serializer took a result that was not ready");

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

@@ tb/int64_to_decimal_ascii_tb.sv @@
// Testbench for int64_to_decimal_ascii: directed and random traffic, predicted character stream, per-char check.
module int64_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [i2da_pkg::VALUE_W-1:0] MAX_POS = {1'b0, {(i2da_pkg::VALUE_W-1){1'b1}}};
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int TAIL_CYCLES  = 150;

  typedef struct packed {
    logic [i2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } text_char_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic signed [i2da_pkg::VALUE_W-1:0] in_value  = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [i2da_pkg::CHAR_W-1:0]         out_char;
  logic                                out_last;

  text_char_t  pending_chars[$];
  text_char_t  want;
  int          mismatches  = 0;
  int          burst_left  = 0;
  int          gap_cycles  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          mode_left   = 0;
  int          stall_phase = 0;

  int64_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [i2da_pkg::VALUE_W-1:0] pow10(input int n);
    logic [i2da_pkg::VALUE_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // Append the decimal text of v to the queue of characters still due.
  function automatic void spell_decimal(input logic [i2da_pkg::VALUE_W-1:0] v);
    logic [i2da_pkg::CHAR_W-1:0]  nul [4] = '{i2da_pkg::CHAR_N, i2da_pkg::CHAR_U,
                                             i2da_pkg::CHAR_L, i2da_pkg::CHAR_L};
    logic [i2da_pkg::VALUE_W-1:0] mag;
    logic [3:0]                   digs [20];
    int                           nd;
    text_char_t                   c;
    if (v == i2da_pkg::NULL_MARK) begin
      for (int i = 0; i < 4; i++) begin
        c.ch   = nul[i];
        c.last = (i == 3);
        pending_chars.push_back(c);
      end
      return;
    end
    nd = 0;
    if (v[i2da_pkg::VALUE_W-1]) begin
      mag    = ~v + 64'd1;
      c.ch   = i2da_pkg::CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end else begin
      mag = v;
    end
    do begin
      digs[nd] = 4'(mag % 64'd10);
      mag      = mag / 64'd10;
      nd++;
    end while (mag != 0);
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch   = i2da_pkg::CHAR_W'(i2da_pkg::CHAR_ZERO + {3'b000, digs[i]});
      c.last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // Uniform value with exactly ndig decimal digits, optionally negated.
  function automatic logic [i2da_pkg::VALUE_W-1:0] random_value(input int ndig, input bit neg);
    logic [i2da_pkg::VALUE_W-1:0] lo, span, r, m;
    lo   = (ndig == 1) ? '0 : pow10(ndig - 1);
    span = (ndig == 19) ? (MAX_POS - lo + 64'd1) : (pow10(ndig) - lo);
    r    = {$urandom, $urandom};
    m    = lo + r % span;
    return neg ? (~m + 64'd1) : m;
  endfunction

  // Issue one request; a new burst opens with a random gap.
  task automatic send_value(input logic [i2da_pkg::VALUE_W-1:0] v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
    end else begin
      gap_cycles = 0;
    end
    burst_left--;
    if (gap_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    spell_decimal(v);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  task automatic test_directed_edges();
    send_value('0);
    send_value(64'd1);
    send_value(-64'sd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(-64'sd9);
    send_value(-64'sd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd1234567890);
    send_value(-64'sd1234567890);
    send_value(pow10(18) - 64'd1);
    send_value(pow10(18));
    send_value(~pow10(18) + 64'd1);
    send_value(MAX_POS);
    send_value(i2da_pkg::NULL_MARK + 64'd1);
    send_value(i2da_pkg::NULL_MARK);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(i2da_pkg::NULL_MARK);
  endtask

  task automatic test_random_lengths(input int count);
    logic [i2da_pkg::VALUE_W-1:0] v;
    int                           k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: v = {$urandom, $urandom};
        1: begin
          k = $urandom_range(0, 5);
          if (k == 0) v = i2da_pkg::NULL_MARK;
          else if (k == 1) v = MAX_POS;
          else if (k == 2) v = i2da_pkg::NULL_MARK + 64'd1;
          else begin
            v = pow10($urandom_range(1, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
            if ($urandom_range(0, 1)) v = ~v + 64'd1;
          end
        end
        default: v = random_value($urandom_range(1, 19), $urandom_range(0, 1));
      endcase
      send_value(v);
    end
  endtask

  // Long texts back to back, hold off until all text is out, then three negative values.
  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) send_value(random_value(19, $urandom_range(0, 1)));
    wait_drained();
    for (int i = 0; i < 3; i++) send_value(random_value($urandom_range(1, 19), 1'b1));
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode  = stall_mode_t'($urandom_range(0, 3));
      mode_left   = $urandom_range(40, 300);
      stall_phase = 0;
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_phase % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: stray char: expected none, actual char %h last %b",
                 $time, out_char, out_last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          $display("%0t: char mismatch: expected %h, actual %h", $time, want.ch, out_char);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_lengths(41);
    test_drain_pause();
    test_random_lengths(41);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: timeout with %0d chars outstanding", $time, pending_chars.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
